// File: design/bcdm_pkg.sv
package bcdm_pkg;

    // field and datapath widths
    localparam int NV_W      = 36;  // cell voltage in nanovolts
    localparam int SDIFF_W   = 37;  // voltage differences, msb is the sign
    localparam int DIVD_W    = 43;  // serial divider dividend and quotient
    localparam int DIVS_W    = 36;  // serial divider divisor and remainder
    localparam int DIV_CNT_W = 6;   // divider iteration counter
    localparam int EFF_W     = 24;  // effective current, tenths of a mA for charge steps, mA for discharge steps
    localparam int STEP_W    = 39;  // voltage step in nanovolts
    localparam int PCT_W     = 7;
    localparam int CFG_DATA_W = 20;
    localparam int REG_IDX_W  = 3;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVD_W - 1);

    // arithmetic constants
    localparam logic [19:0] NV_PER_MV  = 20'd1000000;
    localparam logic [16:0] WINDOW_MV  = 17'd100;
    localparam logic [18:0] CHG_STEP_K = 19'd27770;   // nV per 0.1 mA per mAh
    localparam logic [18:0] DIS_STEP_K = 19'd277700;  // nV per mA per mAh
    localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY    = 7'd0;
    localparam logic [PCT_W-1:0] SOC_LOW_PCT  = 7'd5;
    localparam logic [PCT_W-1:0] SOC_HIGH_PCT = 7'd85;

    // commands
    localparam logic [2:0] CMD_CONN_CHG  = 3'd0;
    localparam logic [2:0] CMD_DROP_CHG  = 3'd1;
    localparam logic [2:0] CMD_CHARGE    = 3'd2;
    localparam logic [2:0] CMD_CONN_LOAD = 3'd3;
    localparam logic [2:0] CMD_DROP_LOAD = 3'd4;
    localparam logic [2:0] CMD_DISCHARGE = 3'd5;
    localparam logic [2:0] CMD_SET_VOLT  = 3'd6;

    // result status codes
    localparam logic [3:0] ST_NONE        = 4'd0;
    localparam logic [3:0] ST_BAD_VOLT    = 4'd1;
    localparam logic [3:0] ST_BAD_CURR    = 4'd2;
    localparam logic [3:0] ST_CHG_ON      = 4'd3;
    localparam logic [3:0] ST_CHG_OFF     = 4'd4;
    localparam logic [3:0] ST_CHARGING    = 4'd5;
    localparam logic [3:0] ST_FULL        = 4'd6;
    localparam logic [3:0] ST_LOAD_ON     = 4'd7;
    localparam logic [3:0] ST_LOAD_OFF    = 4'd8;
    localparam logic [3:0] ST_DISCHARGING = 4'd9;
    localparam logic [3:0] ST_LOW         = 4'd10;
    localparam logic [3:0] ST_SET         = 4'd11;

    // state of charge zones for the charge taper
    localparam logic [1:0] ZONE_LOW  = 2'd0;
    localparam logic [1:0] ZONE_MID  = 2'd1;
    localparam logic [1:0] ZONE_HIGH = 2'd2;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_MIN_V    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_V    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NOM_V    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CHG_V    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_CHG  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAX_OUT  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 3'd6;

    // configuration reset values
    localparam logic [15:0] RST_MIN_V    = 16'd10500;
    localparam logic [15:0] RST_MAX_V    = 16'd12600;
    localparam logic [15:0] RST_NOM_V    = 16'd12000;
    localparam logic [15:0] RST_CHG_V    = 16'd12600;
    localparam logic [19:0] RST_MAX_CHG  = 20'd10000;
    localparam logic [19:0] RST_MAX_OUT  = 20'd20000;
    localparam logic [19:0] RST_CAPACITY = 20'd50000;

    typedef struct packed {
        logic [15:0] min_voltage_mv;
        logic [15:0] max_voltage_mv;
        logic [15:0] nominal_voltage_mv;
        logic [15:0] charging_voltage_mv;
        logic [19:0] max_charge_current_ma;
        logic [19:0] max_output_current_ma;
        logic [19:0] capacity_mah;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] supply_mv;
        logic [19:0] current_ma;
    } in_item_t;

    typedef struct packed {
        logic [3:0]       status;
        logic [NV_W-1:0]  battery_nv;
        logic [PCT_W-1:0] charge_percent;
        logic             charger_on;
        logic             load_on;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_ACT,
        S_MEAS,
        S_SOC_START,
        S_SOC_WAIT,
        S_STEP_START,
        S_STEP_MUL,
        S_STEP_WAIT,
        S_APPLY,
        S_FINISH
    } state_t;

endpackage

// File: design/bcdm_cfg.sv
module bcdm_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [bcdm_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [bcdm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bcdm_pkg::cfg_t                      cfg
);

    bcdm_pkg::cfg_t cfg_reg;
    bcdm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                bcdm_pkg::REG_MIN_V:    cfg_next.min_voltage_mv        = cfg_data[15:0];
                bcdm_pkg::REG_MAX_V:    cfg_next.max_voltage_mv        = cfg_data[15:0];
                bcdm_pkg::REG_NOM_V:    cfg_next.nominal_voltage_mv    = cfg_data[15:0];
                bcdm_pkg::REG_CHG_V:    cfg_next.charging_voltage_mv   = cfg_data[15:0];
                bcdm_pkg::REG_MAX_CHG:  cfg_next.max_charge_current_ma = cfg_data[19:0];
                bcdm_pkg::REG_MAX_OUT:  cfg_next.max_output_current_ma = cfg_data[19:0];
                bcdm_pkg::REG_CAPACITY: cfg_next.capacity_mah          = cfg_data[19:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_voltage_mv        <= bcdm_pkg::RST_MIN_V;
            cfg_reg.max_voltage_mv        <= bcdm_pkg::RST_MAX_V;
            cfg_reg.nominal_voltage_mv    <= bcdm_pkg::RST_NOM_V;
            cfg_reg.charging_voltage_mv   <= bcdm_pkg::RST_CHG_V;
            cfg_reg.max_charge_current_ma <= bcdm_pkg::RST_MAX_CHG;
            cfg_reg.max_output_current_ma <= bcdm_pkg::RST_MAX_OUT;
            cfg_reg.capacity_mah          <= bcdm_pkg::RST_CAPACITY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/bcdm_divider.sv
module bcdm_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [bcdm_pkg::DIVD_W-1:0]      dividend,
    input  logic [bcdm_pkg::DIVS_W-1:0]      divisor,
    output logic                             done,
    output logic [bcdm_pkg::DIVD_W-1:0]      quotient,
    output logic [bcdm_pkg::DIVS_W-1:0]      remainder
);

    // restoring division, one quotient bit per cycle; the dividend shifts
    // out of num_reg at the top while quotient bits shift in at the bottom
    logic [bcdm_pkg::DIVD_W-1:0]    num_reg, num_next;
    logic [bcdm_pkg::DIVS_W-1:0]    rem_reg, rem_next;
    logic [bcdm_pkg::DIVS_W-1:0]    den_reg, den_next;
    logic [bcdm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [bcdm_pkg::DIVS_W:0]      trial;
    logic [bcdm_pkg::DIVS_W:0]      trial_diff;
    logic                           fits;

    always_comb
    begin
        trial      = {rem_reg, num_reg[bcdm_pkg::DIVD_W-1]};
        trial_diff = trial - {1'b0, den_reg};
        fits       = (trial >= {1'b0, den_reg});

        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = bcdm_pkg::DIV_LAST;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_diff[bcdm_pkg::DIVS_W-1:0]
                            : trial[bcdm_pkg::DIVS_W-1:0];
            num_next = {num_reg[bcdm_pkg::DIVD_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

    // the sequencer never restarts a division in flight
    assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
        else $error("divider started while busy");

    // completion only follows an active division
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg))
        else $error("divider done without a division");

endmodule

// File: design/battery_charge_discharge_model.sv
// Battery pack model: keeps the cell voltage in nanovolts plus charger and load
// connected flags, and answers every command item with exactly one result item
// (status, voltage after the command, state of charge in percent, both flags).
// Connect, charge step and discharge step commands first check the supply
// voltage against a +/-100 mV window and the current against its limit. Each
// charge or discharge step stands for one second of current flow. All division
// goes through one shared bit-serial restoring divider. Connect, drop,
// set-voltage, unknown and rejected commands need one state of charge
// division, a discharge step needs a voltage step plus a state of charge, and
// a charge step needs a taper zone, a voltage step and a state of charge. A
// state of charge that needs no division (cell at or below empty, or full
// voltage not above empty voltage) resolves without the divider. One item is
// in work at a time and the next one can be taken in the cycle after the
// result is handed to the output register; a finished result sits in that
// register, so the next item is taken while that result still waits, and
// only a result that finds the register still stalled holds the sequencer.
// Configuration registers are written through a plain write port and must
// only change while the block is idle.
module battery_charge_discharge_model (
    input  logic                             clk,
    input  logic                             rst_n,

    // configuration write port
    input  logic                             cfg_write,
    input  logic [bcdm_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [bcdm_pkg::CFG_DATA_W-1:0]  cfg_data,

    // command items
    input  logic                             in_valid,
    output logic                             in_stall,
    input  bcdm_pkg::in_item_t               in_item,

    // result items
    output logic                             out_valid,
    input  logic                             out_stall,
    output bcdm_pkg::out_item_t              out_item
);

    bcdm_pkg::cfg_t cfg;

    // sequencer and architectural state
    bcdm_pkg::state_t                   state_reg, state_next;
    bcdm_pkg::in_item_t                 item_reg, item_next;
    logic [bcdm_pkg::NV_W-1:0]          volt_reg, volt_next;
    logic                               chg_reg, chg_next;
    logic                               load_reg, load_next;

    // working registers for one item
    logic [bcdm_pkg::NV_W-1:0]          lo_nv_reg, lo_nv_next;
    logic [bcdm_pkg::NV_W-1:0]          hi_nv_reg, hi_nv_next;
    logic                               win_fail_reg, win_fail_next;
    logic                               cur_fail_reg, cur_fail_next;
    logic [bcdm_pkg::SDIFF_W-1:0]       d_reg, d_next;
    logic [bcdm_pkg::SDIFF_W-1:0]       span_reg, span_next;
    logic                               zone_pass_reg, zone_pass_next;
    logic [1:0]                         zone_reg, zone_next;
    logic [bcdm_pkg::EFF_W-1:0]         eff_reg, eff_next;
    logic [bcdm_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [3:0]                         status_reg, status_next;
    logic [bcdm_pkg::PCT_W-1:0]         pct_reg, pct_next;

    // output register
    logic                               out_valid_reg, out_valid_next;
    bcdm_pkg::out_item_t                out_item_reg, out_item_next;

    // shared divider
    logic                               div_start;
    logic [bcdm_pkg::DIVD_W-1:0]        div_dividend;
    logic [bcdm_pkg::DIVS_W-1:0]        div_divisor;
    logic                               div_done;
    logic [bcdm_pkg::DIVD_W-1:0]        div_quot;
    logic [bcdm_pkg::DIVS_W-1:0]        div_rem;

    // combinational helpers
    logic                               in_take;
    logic                               out_free;
    logic                               use_chg_side;
    logic [15:0]                        centre_mv;
    logic [19:0]                        limit_ma;
    logic [16:0]                        supply_ext;
    logic [16:0]                        centre_ext;
    logic                               span_pos;
    logic                               d_neg;
    logic                               d_zero;
    logic [bcdm_pkg::DIVD_W-1:0]        d_x100;
    logic                               q_hi_zero;
    logic [bcdm_pkg::PCT_W-1:0]         q_lo;
    logic [bcdm_pkg::EFF_W-1:0]         cur_x10;
    logic [bcdm_pkg::EFF_W-1:0]         lim_lo;
    logic [bcdm_pkg::EFF_W-1:0]         lim_hi;
    logic [18:0]                        step_k;
    logic [bcdm_pkg::DIVD_W-1:0]        step_prod;
    logic [19:0]                        cap_eff;
    logic [bcdm_pkg::NV_W+3:0]          chg_sum;
    logic [bcdm_pkg::NV_W+3:0]          dis_floor;
    logic [bcdm_pkg::NV_W+3:0]          dis_diff;

    bcdm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcdm_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // one item in work at a time
    assign in_stall = (state_reg != bcdm_pkg::S_IDLE);
    assign in_take  = in_valid && !in_stall;
    // output register can take a new result this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        // charger side checks for connect-charger and charge step, load side otherwise
        use_chg_side = (item_reg.command == bcdm_pkg::CMD_CONN_CHG) ||
                       (item_reg.command == bcdm_pkg::CMD_CHARGE);
        centre_mv    = use_chg_side ? cfg.charging_voltage_mv : cfg.nominal_voltage_mv;
        limit_ma     = use_chg_side ? cfg.max_charge_current_ma
                                    : cfg.max_output_current_ma;
        supply_ext   = {1'b0, item_reg.supply_mv};
        centre_ext   = {1'b0, centre_mv};

        // soc operands: msb of d and span is the sign
        span_pos  = !span_reg[bcdm_pkg::SDIFF_W-1] && (span_reg != '0);
        d_neg     = d_reg[bcdm_pkg::SDIFF_W-1];
        d_zero    = (d_reg == '0);
        d_x100    = ({7'd0, d_reg[bcdm_pkg::NV_W-1:0]} << 6) +
                    ({7'd0, d_reg[bcdm_pkg::NV_W-1:0]} << 5) +
                    ({7'd0, d_reg[bcdm_pkg::NV_W-1:0]} << 2);

        // quotient split for the small percent compares
        q_hi_zero = (div_quot[bcdm_pkg::DIVD_W-1:bcdm_pkg::PCT_W] == '0);
        q_lo      = div_quot[bcdm_pkg::PCT_W-1:0];

        // charge taper: current in tenths of a mA
        cur_x10 = ({4'd0, item_reg.current_ma} << 3) + ({4'd0, item_reg.current_ma} << 1);
        lim_lo  = {4'd0, cfg.max_charge_current_ma};
        lim_hi  = {4'd0, cfg.max_charge_current_ma} << 1;

        // voltage step numerator
        step_k    = (item_reg.command == bcdm_pkg::CMD_CHARGE) ? bcdm_pkg::CHG_STEP_K
                                                               : bcdm_pkg::DIS_STEP_K;
        step_prod = {19'd0, eff_reg} * {24'd0, step_k};
        cap_eff   = (cfg.capacity_mah == '0) ? 20'd1 : cfg.capacity_mah;

        // step application
        chg_sum   = {4'd0, volt_reg} + {1'b0, step_reg};
        dis_floor = {4'd0, lo_nv_reg} + {1'b0, step_reg};
        dis_diff  = {4'd0, volt_reg} - {1'b0, step_reg};
    end

    // divider operand select: soc division or voltage step division
    always_comb
    begin
        if (state_reg == bcdm_pkg::S_SOC_START)
        begin
            div_dividend = d_x100;
            div_divisor  = span_reg[bcdm_pkg::DIVS_W-1:0];
        end
        else
        begin
            div_dividend = step_prod;
            div_divisor  = {16'd0, cap_eff};
        end
    end

    // next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        volt_next      = volt_reg;
        chg_next       = chg_reg;
        load_next      = load_reg;
        lo_nv_next     = lo_nv_reg;
        hi_nv_next     = hi_nv_reg;
        win_fail_next  = win_fail_reg;
        cur_fail_next  = cur_fail_reg;
        d_next         = d_reg;
        span_next      = span_reg;
        zone_pass_next = zone_pass_reg;
        zone_next      = zone_reg;
        eff_next       = eff_reg;
        step_next      = step_reg;
        status_next    = status_reg;
        pct_next       = pct_reg;
        out_item_next  = out_item_reg;
        div_start      = 1'b0;

        // result leaves when taken
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            bcdm_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    item_next  = in_item;
                    state_next = bcdm_pkg::S_PREP;
                end
            end

            // scale the window voltages and run the supply checks
            bcdm_pkg::S_PREP:
            begin
                lo_nv_next    = {20'd0, cfg.min_voltage_mv} * {16'd0, bcdm_pkg::NV_PER_MV};
                hi_nv_next    = {20'd0, cfg.max_voltage_mv} * {16'd0, bcdm_pkg::NV_PER_MV};
                win_fail_next = (supply_ext + bcdm_pkg::WINDOW_MV < centre_ext) ||
                                (supply_ext > centre_ext + bcdm_pkg::WINDOW_MV);
                cur_fail_next = (item_reg.current_ma > limit_ma);
                zone_pass_next = 1'b0;
                state_next    = bcdm_pkg::S_ACT;
            end

            // command decode; simple commands finish here apart from the soc
            bcdm_pkg::S_ACT:
            begin
                state_next  = bcdm_pkg::S_MEAS;
                status_next = bcdm_pkg::ST_NONE;
                case (item_reg.command)
                    bcdm_pkg::CMD_CONN_CHG,
                    bcdm_pkg::CMD_CONN_LOAD:
                    begin
                        if (win_fail_reg)
                        begin
                            status_next = bcdm_pkg::ST_BAD_VOLT;
                        end
                        else if (cur_fail_reg)
                        begin
                            status_next = bcdm_pkg::ST_BAD_CURR;
                        end
                        else if (item_reg.command == bcdm_pkg::CMD_CONN_CHG)
                        begin
                            chg_next    = 1'b1;
                            status_next = bcdm_pkg::ST_CHG_ON;
                        end
                        else
                        begin
                            load_next   = 1'b1;
                            status_next = bcdm_pkg::ST_LOAD_ON;
                        end
                    end
                    bcdm_pkg::CMD_DROP_CHG:
                    begin
                        chg_next    = 1'b0;
                        status_next = bcdm_pkg::ST_CHG_OFF;
                    end
                    bcdm_pkg::CMD_DROP_LOAD:
                    begin
                        load_next   = 1'b0;
                        status_next = bcdm_pkg::ST_LOAD_OFF;
                    end
                    bcdm_pkg::CMD_CHARGE:
                    begin
                        if (!chg_reg)
                        begin
                            status_next = bcdm_pkg::ST_NONE;
                        end
                        else if (win_fail_reg)
                        begin
                            status_next = bcdm_pkg::ST_BAD_VOLT;
                        end
                        else if (cur_fail_reg)
                        begin
                            status_next = bcdm_pkg::ST_BAD_CURR;
                        end
                        else
                        begin
                            // taper zone needs the soc before the step
                            zone_pass_next = 1'b1;
                        end
                    end
                    bcdm_pkg::CMD_DISCHARGE:
                    begin
                        if (win_fail_reg)
                        begin
                            status_next = bcdm_pkg::ST_BAD_VOLT;
                        end
                        else if (cur_fail_reg)
                        begin
                            status_next = bcdm_pkg::ST_BAD_CURR;
                        end
                        else
                        begin
                            state_next = bcdm_pkg::S_STEP_START;
                        end
                    end
                    bcdm_pkg::CMD_SET_VOLT:
                    begin
                        volt_next   = {20'd0, item_reg.supply_mv} *
                                      {16'd0, bcdm_pkg::NV_PER_MV};
                        status_next = bcdm_pkg::ST_SET;
                    end
                    default:
                    begin
                        status_next = bcdm_pkg::ST_NONE;
                    end
                endcase
            end

            // distance above empty and full-scale span, signed
            bcdm_pkg::S_MEAS:
            begin
                d_next     = {1'b0, volt_reg} - {1'b0, lo_nv_reg};
                span_next  = {1'b0, hi_nv_reg} - {1'b0, lo_nv_reg};
                state_next = bcdm_pkg::S_SOC_START;
            end

            // edge cases resolve at once, otherwise divide d*100 by span
            bcdm_pkg::S_SOC_START:
            begin
                if (!span_pos)
                begin
                    // degenerate span: all or nothing
                    if (zone_pass_reg)
                    begin
                        zone_next  = d_neg ? bcdm_pkg::ZONE_LOW : bcdm_pkg::ZONE_HIGH;
                        state_next = bcdm_pkg::S_STEP_START;
                    end
                    else
                    begin
                        pct_next   = d_neg ? bcdm_pkg::PCT_EMPTY : bcdm_pkg::PCT_FULL;
                        state_next = bcdm_pkg::S_FINISH;
                    end
                end
                else if (d_neg || d_zero)
                begin
                    // at or below empty
                    if (zone_pass_reg)
                    begin
                        zone_next  = bcdm_pkg::ZONE_LOW;
                        state_next = bcdm_pkg::S_STEP_START;
                    end
                    else
                    begin
                        pct_next   = bcdm_pkg::PCT_EMPTY;
                        state_next = bcdm_pkg::S_FINISH;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = bcdm_pkg::S_SOC_WAIT;
                end
            end

            bcdm_pkg::S_SOC_WAIT:
            begin
                if (div_done)
                begin
                    if (zone_pass_reg)
                    begin
                        // above 85 includes exactly 85 with a nonzero remainder
                        if (q_hi_zero && (q_lo < bcdm_pkg::SOC_LOW_PCT))
                        begin
                            zone_next = bcdm_pkg::ZONE_LOW;
                        end
                        else if (!q_hi_zero || (q_lo > bcdm_pkg::SOC_HIGH_PCT) ||
                                 ((q_lo == bcdm_pkg::SOC_HIGH_PCT) && (div_rem != '0)))
                        begin
                            zone_next = bcdm_pkg::ZONE_HIGH;
                        end
                        else
                        begin
                            zone_next = bcdm_pkg::ZONE_MID;
                        end
                        state_next = bcdm_pkg::S_STEP_START;
                    end
                    else
                    begin
                        if (!q_hi_zero || (q_lo > bcdm_pkg::PCT_FULL))
                        begin
                            pct_next = bcdm_pkg::PCT_FULL;
                        end
                        else
                        begin
                            pct_next = q_lo;
                        end
                        state_next = bcdm_pkg::S_FINISH;
                    end
                end
            end

            // effective current, tapered for charge steps
            bcdm_pkg::S_STEP_START:
            begin
                if (item_reg.command == bcdm_pkg::CMD_CHARGE)
                begin
                    if ((zone_reg == bcdm_pkg::ZONE_LOW) && (cur_x10 > lim_lo))
                    begin
                        eff_next = lim_lo;
                    end
                    else if ((zone_reg == bcdm_pkg::ZONE_HIGH) && (cur_x10 > lim_hi))
                    begin
                        eff_next = lim_hi;
                    end
                    else
                    begin
                        eff_next = cur_x10;
                    end
                end
                else
                begin
                    eff_next = {4'd0, item_reg.current_ma};
                end
                state_next = bcdm_pkg::S_STEP_MUL;
            end

            // numerator goes straight into the divider register
            bcdm_pkg::S_STEP_MUL:
            begin
                div_start  = 1'b1;
                state_next = bcdm_pkg::S_STEP_WAIT;
            end

            bcdm_pkg::S_STEP_WAIT:
            begin
                if (div_done)
                begin
                    step_next  = div_quot[bcdm_pkg::STEP_W-1:0];
                    state_next = bcdm_pkg::S_APPLY;
                end
            end

            bcdm_pkg::S_APPLY:
            begin
                if (item_reg.command == bcdm_pkg::CMD_CHARGE)
                begin
                    if (chg_sum < {4'd0, hi_nv_reg})
                    begin
                        volt_next   = chg_sum[bcdm_pkg::NV_W-1:0];
                        status_next = bcdm_pkg::ST_CHARGING;
                    end
                    else
                    begin
                        chg_next    = 1'b0;
                        status_next = bcdm_pkg::ST_FULL;
                    end
                end
                else
                begin
                    // v - step > empty, kept unsigned as v > empty + step
                    if ({4'd0, volt_reg} > dis_floor)
                    begin
                        volt_next   = dis_diff[bcdm_pkg::NV_W-1:0];
                        status_next = bcdm_pkg::ST_DISCHARGING;
                    end
                    else
                    begin
                        load_next   = 1'b0;
                        status_next = bcdm_pkg::ST_LOW;
                    end
                end
                // soc of the new voltage
                zone_pass_next = 1'b0;
                state_next     = bcdm_pkg::S_MEAS;
            end

            bcdm_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_item_next.status         = status_reg;
                    out_item_next.battery_nv     = volt_reg;
                    out_item_next.charge_percent = pct_reg;
                    out_item_next.charger_on     = chg_reg;
                    out_item_next.load_on        = load_reg;
                    out_valid_next               = 1'b1;
                    state_next                   = bcdm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bcdm_pkg::S_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcdm_pkg::S_IDLE;
            volt_reg      <= '0;
            chg_reg       <= 1'b0;
            load_reg      <= 1'b0;
            zone_pass_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            volt_reg      <= volt_next;
            chg_reg       <= chg_next;
            load_reg      <= load_next;
            zone_pass_reg <= zone_pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        lo_nv_reg    <= lo_nv_next;
        hi_nv_reg    <= hi_nv_next;
        win_fail_reg <= win_fail_next;
        cur_fail_reg <= cur_fail_next;
        d_reg        <= d_next;
        span_reg     <= span_next;
        zone_reg     <= zone_next;
        eff_reg      <= eff_next;
        step_reg     <= step_next;
        status_reg   <= status_next;
        pct_reg      <= pct_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // state of charge is saturated
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.charge_percent <= bcdm_pkg::PCT_FULL))
        else $error("charge percent above full");

    // a charging result always reports the charger still connected
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_item_reg.status == bcdm_pkg::ST_CHARGING))
            |-> out_item_reg.charger_on)
        else $error("charging result without charger");

    // only charge and discharge steps apply a voltage step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bcdm_pkg::S_APPLY) |->
            ((item_reg.command == bcdm_pkg::CMD_CHARGE) ||
             (item_reg.command == bcdm_pkg::CMD_DISCHARGE)))
        else $error("voltage step for a non-step command");

endmodule
